/* rtl/core/checksummed_command_frame_receiver_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the command frame receiver
// Concurrent checks with a synchronous active-low reset as disable.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CHECKSUMMED_COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication
`define CRX_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("crx assertion failed");

// Next-cycle implication
`define CRX_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("crx assertion failed");

`endif

/* rtl/core/crx_pkg.sv */
// ----------------------------------------------------------------------------
// crx_pkg
// Shared types, codes and defaults of the command frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crx_pkg;

    localparam int          BUF_DEPTH_DEF  = 256;
    localparam logic [7:0]  IDLE_LIMIT_RST = 8'd20;

    // Frame header bytes
    localparam logic [7:0]  HDR_FIRST  = 8'h3B;
    localparam logic [7:0]  HDR_SECOND = 8'h2C;

    // Scanner and display commands
    localparam logic [7:0]  CMD_SCAN_HIGH = 8'hB0;
    localparam logic [7:0]  CMD_SCAN_LOW  = 8'hB1;
    localparam logic [7:0]  CMD_PWR_OFF   = 8'hB2;
    localparam logic [7:0]  CMD_PWR_ON    = 8'hB3;
    localparam logic [7:0]  CMD_LANG_EN   = 8'hB4;
    localparam logic [7:0]  CMD_LANG_BIG5 = 8'hB5;
    localparam logic [7:0]  CMD_LANG_GB   = 8'hB6;
    localparam logic [7:0]  CMD_BL_ON     = 8'hB9;
    localparam logic [7:0]  CMD_BL_OFF    = 8'hBA;

    // Commands that select a page
    localparam int          NUM_PAGES = 14;
    localparam logic [7:0]  PAGE_CMDS [NUM_PAGES] = '{
        8'h00, 8'h0A, 8'h0B, 8'h14, 8'h15, 8'h1E, 8'h1F,
        8'h28, 8'h29, 8'h2A, 8'h2B, 8'h32, 8'h3C, 8'h46
    };

    // One input item as held in the input register
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    // Frame completion reported by the parser
    typedef struct packed {
        logic       done;
        logic       ok;
        logic [7:0] command;
        logic [7:0] frame_length;
    } t_frame_evt;

    // One result item
    typedef struct packed {
        logic       frame_ok;
        logic [7:0] command;
        logic [7:0] frame_length;
        logic [7:0] page;
        logic       scan_line;
        logic       scanner_power_line;
        logic       backlight_on;
        logic [1:0] language;
        logic       language_changed;
        logic       scan_start;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/crx_in_if.sv */
// ----------------------------------------------------------------------------
// crx_in_if
// Input channel: received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface crx_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/crx_out_if.sv */
// ----------------------------------------------------------------------------
// crx_out_if
// Result channel: one item per completed frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface crx_out_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic [7:0] command;
    logic [7:0] frame_length;
    logic [7:0] page;
    logic       scan_line;
    logic       scanner_power_line;
    logic       backlight_on;
    logic [1:0] language;
    logic       language_changed;
    logic       scan_start;

    modport source (
        output valid, output frame_ok, output command, output frame_length,
        output page, output scan_line, output scanner_power_line,
        output backlight_on, output language, output language_changed,
        output scan_start, input ready
    );
    modport sink (
        input valid, input frame_ok, input command, input frame_length,
        input page, input scan_line, input scanner_power_line,
        input backlight_on, input language, input language_changed,
        input scan_start, output ready
    );
endinterface

`default_nettype wire

/* rtl/core/crx_cfg_if.sv */
// ----------------------------------------------------------------------------
// crx_cfg_if
// Configuration write channel for the idle limit register.
// ----------------------------------------------------------------------------
`default_nettype none

interface crx_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/crx_parse.sv */
// ----------------------------------------------------------------------------
// crx_parse
// Frame position, header check, running checksum and idle timeout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "checksummed_command_frame_receiver_top_assert.svh"

module crx_parse #(
    parameter int BUF_DEPTH = crx_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire crx_pkg::t_in_item    i_item,
    input  wire logic [7:0]           i_idle_limit,
    output crx_pkg::t_frame_evt       o_evt
);

    localparam int PW = $clog2(BUF_DEPTH);
    localparam int CW = (PW > 9) ? PW : 9;
    localparam logic [PW-1:0] MAX_POS = PW'(BUF_DEPTH - 1);

    logic [PW-1:0] r_pos,  n_pos;
    logic [7:0]    r_sum,  n_sum;
    logic [1:0]    r_hdr,  n_hdr;
    logic [7:0]    r_len,  n_len;
    logic [7:0]    r_cmd,  n_cmd;
    logic [7:0]    r_idle, n_idle;

    logic [7:0]    sum_base;
    logic [8:0]    tick_cnt;
    logic [8:0]    lplus;
    logic [PW-1:0] count;
    logic          sum_ok;
    logic          done;

    // Step the frame state for one accepted item
    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_hdr    = r_hdr;
        n_len    = r_len;
        n_cmd    = r_cmd;
        n_idle   = r_idle;
        sum_base = r_sum;
        tick_cnt = {1'b0, r_idle} + 9'd1;
        lplus    = 9'd0;
        count    = r_pos;
        sum_ok   = 1'b0;
        done     = 1'b0;
        if (i_fire && i_item.mode) begin
            // tick: count idle time, drop the partial frame past the limit
            if (tick_cnt > {1'b0, i_idle_limit}) begin
                n_idle = 8'd0;
                n_pos  = '0;
            end else begin
                n_idle = tick_cnt[7:0];
            end
        end else if (i_fire) begin
            n_idle = 8'd0;
            if (r_pos == '0) begin
                n_hdr    = {1'b0, (i_item.rx_byte == crx_pkg::HDR_FIRST)};
                sum_base = 8'd0;
            end else if (r_pos == PW'(1)) begin
                n_hdr = {(i_item.rx_byte == crx_pkg::HDR_SECOND), r_hdr[0]};
            end else if (r_pos == PW'(2)) begin
                n_len = i_item.rx_byte;
            end else if (r_pos == PW'(3)) begin
                n_cmd = i_item.rx_byte;
            end
            // checksum byte compares against the sum before it
            sum_ok = (sum_base == i_item.rx_byte);
            lplus  = {1'b0, n_len} + 9'd1;
            if (r_pos >= PW'(2) && CW'(r_pos) <= CW'(lplus)) begin
                n_sum = sum_base + i_item.rx_byte;
            end else begin
                n_sum = sum_base;
            end
            // saturate the position at the buffer end
            count = (r_pos == MAX_POS) ? MAX_POS : r_pos + PW'(1);
            done  = (n_hdr == 2'b11) && (count >= PW'(5)) &&
                    (CW'(count) == CW'(n_len) + CW'(3));
            n_pos = done ? '0 : count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= 8'd0;
            r_hdr  <= 2'b00;
            r_len  <= 8'd0;
            r_cmd  <= 8'd0;
            r_idle <= 8'd0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_hdr  <= n_hdr;
            r_len  <= n_len;
            r_cmd  <= n_cmd;
            r_idle <= n_idle;
        end
    end

    assign o_evt.done         = done;
    assign o_evt.ok           = sum_ok;
    assign o_evt.command      = n_cmd;
    assign o_evt.frame_length = n_len;

    `CRX_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= MAX_POS)
    `CRX_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, o_evt.done, r_pos == '0)
    `CRX_ASSERT_NOW(a_tick_no_frame, i_clk, i_rst_n, i_fire && i_item.mode, !o_evt.done)

endmodule

`default_nettype wire

/* rtl/core/crx_exec.sv */
// ----------------------------------------------------------------------------
// crx_exec
// Command execution: page select, scanner pins, backlight and language.
// ----------------------------------------------------------------------------
`default_nettype none

`include "checksummed_command_frame_receiver_top_assert.svh"

module crx_exec (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire crx_pkg::t_frame_evt  i_evt,
    output crx_pkg::t_result          o_res
);

    localparam logic [1:0] LANG_EN   = 2'd0;
    localparam logic [1:0] LANG_BIG5 = 2'd1;
    localparam logic [1:0] LANG_GB   = 2'd2;

    logic [7:0] r_page,  n_page;
    logic       r_scan,  n_scan;
    logic       r_power, n_power;
    logic       r_blight, n_blight;
    logic [1:0] r_lang,  n_lang;
    logic       apply;
    logic       is_page;
    logic       lang_chg;
    logic       scan_go;
    logic       bad_frame;

    // Match the command against the page list
    always_comb begin
        is_page = 1'b0;
        for (int k = 0; k < crx_pkg::NUM_PAGES; k++) begin
            if (i_evt.command == crx_pkg::PAGE_CMDS[k]) begin
                is_page = 1'b1;
            end
        end
    end

    // Apply the command of a frame with a good checksum
    always_comb begin
        apply    = i_fire && i_evt.done && i_evt.ok;
        n_page   = r_page;
        n_scan   = r_scan;
        n_power  = r_power;
        n_blight = r_blight;
        n_lang   = r_lang;
        lang_chg = 1'b0;
        scan_go  = 1'b0;
        if (apply && is_page) begin
            n_page = i_evt.command;
        end else if (apply) begin
            case (i_evt.command)
                crx_pkg::CMD_SCAN_LOW: begin
                    n_scan  = 1'b0;
                    scan_go = 1'b1;
                end
                crx_pkg::CMD_SCAN_HIGH: n_scan   = 1'b1;
                crx_pkg::CMD_PWR_OFF:   n_power  = 1'b0;
                crx_pkg::CMD_PWR_ON:    n_power  = 1'b1;
                crx_pkg::CMD_LANG_EN: begin
                    n_lang   = LANG_EN;
                    lang_chg = 1'b1;
                end
                crx_pkg::CMD_LANG_BIG5: begin
                    n_lang   = LANG_BIG5;
                    lang_chg = 1'b1;
                end
                crx_pkg::CMD_LANG_GB: begin
                    n_lang   = LANG_GB;
                    lang_chg = 1'b1;
                end
                crx_pkg::CMD_BL_ON:     n_blight = 1'b1;
                crx_pkg::CMD_BL_OFF:    n_blight = 1'b0;
                default: begin
                    n_scan = r_scan;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page   <= 8'd0;
            r_scan   <= 1'b1;
            r_power  <= 1'b0;
            r_blight <= 1'b0;
            r_lang   <= LANG_EN;
        end else begin
            r_page   <= n_page;
            r_scan   <= n_scan;
            r_power  <= n_power;
            r_blight <= n_blight;
            r_lang   <= n_lang;
        end
    end

    // Result shows the state after this frame
    assign o_res.frame_ok           = i_evt.ok;
    assign o_res.command            = i_evt.command;
    assign o_res.frame_length       = i_evt.frame_length;
    assign o_res.page               = n_page;
    assign o_res.scan_line          = n_scan;
    assign o_res.scanner_power_line = n_power;
    assign o_res.backlight_on       = n_blight;
    assign o_res.language           = n_lang;
    assign o_res.language_changed   = lang_chg;
    assign o_res.scan_start         = scan_go;

    assign bad_frame = i_fire && i_evt.done && !i_evt.ok;

    `CRX_ASSERT_NEXT(a_bad_sum_hold, i_clk, i_rst_n, bad_frame, $stable({r_page, r_lang, r_scan}))

endmodule

`default_nettype wire

/* rtl/core/checksummed_command_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// checksummed_command_frame_receiver_top
// Length-prefixed command frame receiver with additive checksum.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     mode, rx_byte
//  o_out     out  valid/ready     frame_ok .. scan_start (one item per frame)
//  i_cfg     in   valid/ready     data = idle_limit
//
//  One input item is taken every cycle while o_out is not stalled; a result
//  passes the input register, then the result register, before o_out.
//  The frame state update is a single pass between those two registers.
//  Reset clears frame state, pins (scan line high) and sets idle_limit to 20.
//  A stalled result holds o_out and blocks input only while it cannot move.
// ----------------------------------------------------------------------------
`default_nettype none

`include "checksummed_command_frame_receiver_top_assert.svh"

module checksummed_command_frame_receiver_top #(
    parameter int BUF_DEPTH = crx_pkg::BUF_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    crx_in_if.sink      i_in,
    crx_out_if.source   o_out,
    crx_cfg_if.sink     i_cfg
);

    logic                r_in_valid;
    crx_pkg::t_in_item   r_in;
    logic                r_out_valid;
    crx_pkg::t_result    r_out;
    logic [7:0]          r_idle_limit;
    logic                s_adv;
    crx_pkg::t_frame_evt evt;
    crx_pkg::t_result    res;

    // Advance the held item when the result side can take it
    assign s_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s_adv;
    assign i_cfg.ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.mode    <= i_in.mode;
            r_in.rx_byte <= i_in.rx_byte;
        end
    end

    // Idle limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= crx_pkg::IDLE_LIMIT_RST;
        end else if (i_cfg.valid) begin
            r_idle_limit <= i_cfg.data;
        end
    end

    crx_parse #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s_adv),
        .i_item       (r_in),
        .i_idle_limit (r_idle_limit),
        .o_evt        (evt)
    );

    crx_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s_adv),
        .i_evt   (evt),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv && evt.done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && evt.done) begin
            r_out <= res;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.frame_ok           = r_out.frame_ok;
    assign o_out.command            = r_out.command;
    assign o_out.frame_length       = r_out.frame_length;
    assign o_out.page               = r_out.page;
    assign o_out.scan_line          = r_out.scan_line;
    assign o_out.scanner_power_line = r_out.scanner_power_line;
    assign o_out.backlight_on       = r_out.backlight_on;
    assign o_out.language           = r_out.language;
    assign o_out.language_changed   = r_out.language_changed;
    assign o_out.scan_start         = r_out.scan_start;

    `CRX_ASSERT_NEXT(a_out_kept, i_clk, i_rst_n, r_out_valid && !o_out.ready, r_out_valid)
    `CRX_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_out_valid && !o_out.ready, !s_adv)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command frame receiver. A queue of bytes and
// ticks feeds a valid/ready driver; each accepted item updates a local frame
// decoder that queues the expected frame reports, which the monitor compares
// field by field against the result channel. The idle limit is rewritten
// between phases while the block is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int         FRAME_CAP     = crx_pkg::BUF_DEPTH_DEF - 1;
    localparam logic [7:0] CMD_UNUSED    = 8'hFF;
    localparam logic       MODE_BYTE     = 1'b0;
    localparam logic       MODE_TICK     = 1'b1;

    localparam logic [7:0] PIN_CMDS [9] = '{
        crx_pkg::CMD_SCAN_HIGH, crx_pkg::CMD_SCAN_LOW, crx_pkg::CMD_PWR_OFF,
        crx_pkg::CMD_PWR_ON, crx_pkg::CMD_LANG_EN, crx_pkg::CMD_LANG_BIG5,
        crx_pkg::CMD_LANG_GB, crx_pkg::CMD_BL_ON, crx_pkg::CMD_BL_OFF
    };

    bit   i_clk = 1'b0;
    logic i_rst_n;

    crx_in_if  in_ch ();
    crx_out_if out_ch ();
    crx_cfg_if cfg_ch ();

    checksummed_command_frame_receiver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Stimulus and scoreboard storage
    crx_pkg::t_in_item rx_items [$];
    crx_pkg::t_result  reports_due [$];
    crx_pkg::t_in_item next_item;
    int unsigned items_queued;
    int unsigned items_taken;
    int unsigned reports_seen;
    int unsigned mismatches;
    logic [7:0]  gen_limit;
    bit          dirty;
    bit          steady;
    bit          in_took;
    bit          cfg_took;
    bit          hold_used;
    int unsigned hold_left;

    // Frame decoder state
    int unsigned frame_pos;
    logic [7:0]  frame_sum;
    logic [1:0]  sync_seen;
    logic [7:0]  frame_len;
    logic [7:0]  frame_cmd;
    logic [7:0]  idle_cnt;
    logic [7:0]  idle_limit;
    logic [7:0]  page_q;
    logic        scan_q;
    logic        power_q;
    logic        light_q;
    logic [1:0]  lang_q;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit selects_page(input logic [7:0] c);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < crx_pkg::NUM_PAGES; k++) begin
            if (crx_pkg::PAGE_CMDS[k] == c) hit = 1'b1;
        end
        return hit;
    endfunction

    // Advance the frame decoder by one item; queue a report on completion
    task automatic take_rx_item(input logic mode, input logic [7:0] b);
        int unsigned      p;
        int unsigned      cnt;
        logic             sum_ok;
        crx_pkg::t_result rep;
        p = frame_pos;
        rep = '0;
        if (mode == MODE_TICK) begin
            if (int'(idle_cnt) + 1 > int'(idle_limit)) begin
                idle_cnt = 8'd0;
                frame_pos = 0;
            end else begin
                idle_cnt = idle_cnt + 8'd1;
            end
        end else begin
            idle_cnt = 8'd0;
            case (p)
                0: begin
                    sync_seen = (b == crx_pkg::HDR_FIRST) ? 2'b01 : 2'b00;
                    frame_sum = 8'd0;
                end
                1: sync_seen = (b == crx_pkg::HDR_SECOND) ? (sync_seen | 2'b10)
                                                          : (sync_seen & 2'b01);
                2: frame_len = b;
                3: frame_cmd = b;
                default: ;
            endcase
            sum_ok = (frame_sum == b);
            if (p >= 2 && p <= int'(frame_len) + 1) frame_sum = frame_sum + b;
            cnt = (p + 1 > FRAME_CAP) ? FRAME_CAP : p + 1;
            frame_pos = cnt;
            if (sync_seen == 2'b11 && cnt >= 5 && cnt == int'(frame_len) + 3) begin
                frame_pos = 0;
                if (sum_ok) begin
                    if (selects_page(frame_cmd)) begin
                        page_q = frame_cmd;
                    end else begin
                        case (frame_cmd)
                            crx_pkg::CMD_SCAN_LOW: begin
                                scan_q = 1'b0;
                                rep.scan_start = 1'b1;
                            end
                            crx_pkg::CMD_SCAN_HIGH: scan_q = 1'b1;
                            crx_pkg::CMD_PWR_OFF:   power_q = 1'b0;
                            crx_pkg::CMD_PWR_ON:    power_q = 1'b1;
                            crx_pkg::CMD_LANG_EN, crx_pkg::CMD_LANG_BIG5,
                            crx_pkg::CMD_LANG_GB: begin
                                lang_q = 2'(frame_cmd - crx_pkg::CMD_LANG_EN);
                                rep.language_changed = 1'b1;
                            end
                            crx_pkg::CMD_BL_ON:     light_q = 1'b1;
                            crx_pkg::CMD_BL_OFF:    light_q = 1'b0;
                            default: ;
                        endcase
                    end
                end
                rep.frame_ok           = sum_ok;
                rep.command            = frame_cmd;
                rep.frame_length       = frame_len;
                rep.page               = page_q;
                rep.scan_line          = scan_q;
                rep.scanner_power_line = power_q;
                rep.backlight_on       = light_q;
                rep.language           = lang_q;
                reports_due.push_back(rep);
            end
        end
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Sample handshakes, update the decoder and compare reports
    always @(posedge i_clk) begin
        in_took  = i_rst_n && in_ch.valid && in_ch.ready;
        cfg_took = i_rst_n && cfg_ch.valid && cfg_ch.ready;
        if (cfg_took) idle_limit = cfg_ch.data;
        if (in_took) begin
            take_rx_item(in_ch.mode, in_ch.rx_byte);
            items_taken++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            reports_seen++;
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected report expected none actual cmd %0h",
                         $time, out_ch.command);
                mismatches++;
            end else begin
                crx_pkg::t_result want;
                want = reports_due.pop_front();
                check_field("frame_ok", 32'(want.frame_ok), 32'(out_ch.frame_ok));
                check_field("command", 32'(want.command), 32'(out_ch.command));
                check_field("frame_length", 32'(want.frame_length),
                            32'(out_ch.frame_length));
                check_field("page", 32'(want.page), 32'(out_ch.page));
                check_field("scan_line", 32'(want.scan_line), 32'(out_ch.scan_line));
                check_field("scanner_power_line", 32'(want.scanner_power_line),
                            32'(out_ch.scanner_power_line));
                check_field("backlight_on", 32'(want.backlight_on),
                            32'(out_ch.backlight_on));
                check_field("language", 32'(want.language), 32'(out_ch.language));
                check_field("language_changed", 32'(want.language_changed),
                            32'(out_ch.language_changed));
                check_field("scan_start", 32'(want.scan_start), 32'(out_ch.scan_start));
            end
        end
    end

    // Offer the next queued item once the current one is gone
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || in_took)) begin
            if (rx_items.size() != 0 && (steady || $urandom_range(0, 99) >= 13)) begin
                next_item = rx_items.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.mode    <= next_item.mode;
                in_ch.rx_byte <= next_item.rx_byte;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Drive result ready; hold off once for a long stretch to back up the input
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (!hold_used && reports_seen >= 20) begin
            hold_used = 1'b1;
            hold_left = 400;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 13);
        end
    end

    task automatic queue_item(input logic mode, input logic [7:0] b);
        crx_pkg::t_in_item it;
        it.mode    = mode;
        it.rx_byte = b;
        rx_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_ticks(input int unsigned n);
        repeat (n) queue_item(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Push a byte, sometimes after a tick run too short to drop the frame
    task automatic put_byte(input logic [7:0] b, input bit gappy);
        int unsigned gap_max;
        gap_max = (gen_limit < 8'd3) ? 32'(gen_limit) : 3;
        if (gappy && $urandom_range(0, 9) == 0) queue_ticks($urandom_range(1, gap_max));
        queue_item(MODE_BYTE, b);
    endtask

    task automatic queue_frame(input logic [7:0] len, input logic [7:0] cmd,
                               input bit bad_sum, input bit gappy);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned k;
        put_byte(crx_pkg::HDR_FIRST, gappy);
        put_byte(crx_pkg::HDR_SECOND, gappy);
        put_byte(len, gappy);
        put_byte(cmd, gappy);
        sum = len + cmd;
        for (k = 2; k < 32'(len); k++) begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            put_byte(b, gappy);
        end
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        put_byte(sum, gappy);
    endtask

    // Noise and broken frames that leave a partial frame behind
    task automatic queue_junk();
        int unsigned n;
        logic [7:0]  b;
        n = $urandom_range(0, 5);
        case ($urandom_range(0, 3))
            0: begin
                repeat (n + 1) put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                b = 8'($urandom_range(0, 255));
                if (b == crx_pkg::HDR_SECOND) b = b ^ 8'h01;
                put_byte(crx_pkg::HDR_FIRST, 1'b1);
                put_byte(b, 1'b1);
                repeat (n) put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            2: begin
                put_byte(crx_pkg::HDR_FIRST, 1'b1);
                put_byte(crx_pkg::HDR_SECOND, 1'b1);
                put_byte(8'($urandom_range(0, 1)), 1'b1);
                repeat (n) put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                put_byte(crx_pkg::HDR_FIRST, 1'b1);
                put_byte(crx_pkg::HDR_SECOND, 1'b1);
                put_byte(8'(n + 4), 1'b1);
                repeat (n + 1) put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    function automatic logic [7:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'($urandom_range(2, 6));
        if (r < 95) return 8'($urandom_range(7, 20));
        return 8'($urandom_range(21, 60));
    endfunction

    function automatic logic [7:0] pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return crx_pkg::PAGE_CMDS[$urandom_range(0, crx_pkg::NUM_PAGES - 1)];
        if (r < 80) return PIN_CMDS[$urandom_range(0, 8)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed frames, with bad checksums, junk and tick runs mixed in
    task automatic run_phase(input int unsigned n_items, input int unsigned mess_pct);
        int unsigned first;
        int unsigned pick;
        first = items_queued;
        while (items_queued - first < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                if (dirty && $urandom_range(0, 9) != 0) begin
                    queue_ticks(int'(gen_limit) + 1);
                    dirty = 1'b0;
                end
                queue_frame(pick_len(), pick_cmd(), pick >= 72, 1'b1);
            end else if (pick < 82 + mess_pct) begin
                queue_junk();
                dirty = 1'b1;
            end else begin
                queue_ticks($urandom_range(1, 4));
            end
        end
    endtask

    function automatic bit drained();
        return items_taken == items_queued && reports_due.size() == 0;
    endfunction

    // Wait for the block to empty, then let the pipeline settle
    task automatic wait_idle();
        while (!drained()) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_idle_limit(input logic [7:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(negedge i_clk);
        while (!cfg_took) @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        gen_limit = v;
    endtask

    // Main sequence
    initial begin
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_BYTE;
        in_ch.rx_byte = 8'd0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = 8'd0;
        i_rst_n       = 1'b0;
        items_queued  = 0;
        items_taken   = 0;
        reports_seen  = 0;
        mismatches    = 0;
        dirty         = 1'b0;
        steady        = 1'b0;
        in_took       = 1'b0;
        cfg_took      = 1'b0;
        hold_used     = 1'b0;
        hold_left     = 0;
        frame_pos     = 0;
        frame_sum     = 8'd0;
        sync_seen     = 2'b00;
        frame_len     = 8'd0;
        frame_cmd     = 8'd0;
        idle_cnt      = 8'd0;
        idle_limit    = crx_pkg::IDLE_LIMIT_RST;
        gen_limit     = crx_pkg::IDLE_LIMIT_RST;
        page_q        = 8'd0;
        scan_q        = 1'b1;
        power_q       = 1'b0;
        light_q       = 1'b0;
        lang_q        = 2'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: scan start, other command, bad checksum, a tick, page limits
        queue_frame(8'd2, crx_pkg::CMD_SCAN_LOW, 1'b0, 1'b0);
        queue_frame(8'd2, CMD_UNUSED, 1'b0, 1'b0);
        queue_frame(8'd2, crx_pkg::CMD_BL_ON, 1'b1, 1'b0);
        queue_item(MODE_TICK, 8'hFF);
        queue_frame(8'd2, crx_pkg::PAGE_CMDS[0], 1'b0, 1'b0);
        queue_frame(8'd3, crx_pkg::PAGE_CMDS[crx_pkg::NUM_PAGES - 1], 1'b0, 1'b0);
        wait_idle();

        // Idle limit of one, one full-buffer frame
        set_idle_limit(8'd1);
        queue_frame(8'(FRAME_CAP - 3), crx_pkg::CMD_BL_ON, 1'b0, 1'b0);
        run_phase(160, 13);
        wait_idle();

        // Widest idle limit, no idling, a frame that never fits
        set_idle_limit(8'd255);
        steady = 1'b1;
        queue_frame(8'(FRAME_CAP - 3), crx_pkg::CMD_BL_OFF, 1'b0, 1'b0);
        queue_frame(8'(FRAME_CAP - 2), crx_pkg::CMD_PWR_ON, 1'b0, 1'b0);
        dirty = 1'b1;
        run_phase(120, 2);
        wait_idle();
        steady = 1'b0;

        set_idle_limit(8'($urandom_range(2, 40)));
        run_phase(150, 13);
        wait_idle();

        set_idle_limit(8'd6);
        run_phase(100, 13);
        wait_idle();

        if (mismatches == 0) begin
            $display("checksummed_command_frame_receiver_top: match");
        end else begin
            $display("checksummed_command_frame_receiver_top: mismatch");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2400000;
        $display("checksummed_command_frame_receiver_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
